@@ rtl/hvn_pkg.sv @@
// ----------------------------------------------------------------------------
// hvn_pkg
// Shared constants, types and helpers for the hashed 3-D value noise unit.
// ----------------------------------------------------------------------------
package hvn_pkg;

  localparam logic [63:0] MixM1  = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MixM2  = 64'h94d049bb133111eb;
  localparam logic [63:0] AxisXK = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] AxisYK = 64'h94d049bb133111eb;
  localparam logic [63:0] AxisZK = 64'hd1b54a32d192ed03;

  localparam logic [17:0] SmoothThree = 18'd196608;
  localparam logic [15:0] Q16Max      = 16'hffff;

  localparam int DivBits     = 4;
  localparam int DivStages   = 64 / DivBits;
  localparam int FracStages  = 32 / DivBits;

  localparam logic [1:0] RegWorldSeed  = 2'd0;
  localparam logic [1:0] RegStreamSalt = 2'd1;
  localparam logic [1:0] RegHorizScale = 2'd2;
  localparam logic [1:0] RegVertScale  = 2'd3;

  // lane 0: x, lane 1: z, lane 2: vertical
  typedef struct packed {
    logic [15:0] rem;
    logic [63:0] quo;
  } div_lane_t;

  typedef struct packed {
    logic                  valid;
    logic [2:0]            neg;
    div_lane_t [2:0]       lane;
    logic [2:0][63:0]      grid;
  } div_bundle_t;

  function automatic logic [63:0] zigzag(input logic [63:0] u);
    return {u[62:0], 1'b0} ^ {64{u[63]}};
  endfunction

endpackage

@@ rtl/hvn_div_stage.sv @@
// ----------------------------------------------------------------------------
// hvn_div_stage
// One registered stage of the three-lane restoring divider, four quotient
// bits per lane.
// ----------------------------------------------------------------------------
module hvn_div_stage (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic [2:0][15:0]         scale,
  input  hvn_pkg::div_bundle_t     d_in,
  output hvn_pkg::div_bundle_t     d_out
);

  hvn_pkg::div_bundle_t nxt;

  always_comb begin
    logic [16:0] r2;
    logic [15:0] r;
    logic [63:0] q;
    nxt = d_in;
    for (int i = 0; i < 3; i++) begin
      r = d_in.lane[i].rem;
      q = d_in.lane[i].quo;
      for (int k = 0; k < hvn_pkg::DivBits; k++) begin
        r2 = {r, q[63]};
        q  = {q[62:0], 1'b0};
        if (r2 >= {1'b0, scale[i]}) begin
          r2   = r2 - {1'b0, scale[i]};
          q[0] = 1'b1;
        end
        r = r2[15:0];
      end
      nxt.lane[i].rem = r;
      nxt.lane[i].quo = q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_out.valid <= 1'b0;
    end else if (en) begin
      d_out <= nxt;
    end
  end

endmodule

@@ rtl/hvn_mix64.sv @@
// ----------------------------------------------------------------------------
// hvn_mix64
// Four-stage 64-bit finalizer: xorshift, multiply, xorshift, multiply,
// xorshift. Each 64x64 product is split into 32x32 partial products.
// ----------------------------------------------------------------------------
module hvn_mix64 (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] h_in,
  output logic [63:0] h_out
);

  logic [63:0] a;
  logic [63:0] ll1;
  logic [31:0] lh1;
  logic [31:0] hl1;
  logic [63:0] p1;
  logic [63:0] b;
  logic [63:0] ll2;
  logic [31:0] lh2;
  logic [31:0] hl2;
  logic [63:0] p2;

  assign a  = h_in ^ (h_in >> 30);
  assign p1 = ll1 + {lh1 + hl1, 32'b0};
  assign p2 = ll2 + {lh2 + hl2, 32'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      ll1   <= {32'b0, a[31:0]} * {32'b0, hvn_pkg::MixM1[31:0]};
      lh1   <= a[31:0] * hvn_pkg::MixM1[63:32];
      hl1   <= a[63:32] * hvn_pkg::MixM1[31:0];
      b     <= p1 ^ (p1 >> 27);
      ll2   <= {32'b0, b[31:0]} * {32'b0, hvn_pkg::MixM2[31:0]};
      lh2   <= b[31:0] * hvn_pkg::MixM2[63:32];
      hl2   <= b[63:32] * hvn_pkg::MixM2[31:0];
      h_out <= p2 ^ (p2 >> 31);
    end
  end

endmodule

@@ rtl/hvn_ease.sv @@
// ----------------------------------------------------------------------------
// hvn_ease
// Two-stage clamped smoothstep 3t^2 - 2t^3 on a Q16 fraction.
// ----------------------------------------------------------------------------
module hvn_ease (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] t_in,
  output logic [15:0] t_out
);

  logic [31:0] sq;
  logic [15:0] tt;
  logic [15:0] t_q;
  logic [17:0] k;
  logic [33:0] v;

  assign sq = t_in * t_in;
  assign k  = hvn_pkg::SmoothThree - {1'b0, t_q, 1'b0};
  assign v  = {18'b0, tt} * {16'b0, k};

  always_ff @(posedge clk) begin
    if (en) begin
      tt  <= sq[31:16];
      t_q <= t_in;
      t_out <= (v[33:16] > {2'b0, hvn_pkg::Q16Max}) ? hvn_pkg::Q16Max : v[31:16];
    end
  end

endmodule

@@ rtl/hvn_lerp.sv @@
// ----------------------------------------------------------------------------
// hvn_lerp
// Two-stage clamped Q16 lerp; a falling step rounds toward minus infinity.
// ----------------------------------------------------------------------------
module hvn_lerp (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] a,
  input  logic [15:0] b,
  input  logic [15:0] t,
  output logic [15:0] y
);

  logic        up;
  logic [15:0] diff;
  logic        up_q;
  logic [15:0] a_q;
  logic [31:0] prod;
  logic [31:0] rnd;
  logic [16:0] sum;
  logic [16:0] dif;

  assign up   = b >= a;
  assign diff = up ? (b - a) : (a - b);
  assign rnd  = prod + 32'd65535;
  assign sum  = {1'b0, a_q} + {1'b0, prod[31:16]};
  assign dif  = {1'b0, a_q} - {1'b0, rnd[31:16]};

  always_ff @(posedge clk) begin
    if (en) begin
      up_q <= up;
      a_q  <= a;
      prod <= diff * t;
      if (up_q) begin
        y <= sum[16] ? hvn_pkg::Q16Max : sum[15:0];
      end else begin
        y <= dif[16] ? 16'd0 : dif[15:0];
      end
    end
  end

endmodule

@@ rtl/hashed_value_noise_3d_q16_unit.sv @@
// ----------------------------------------------------------------------------
// hashed_value_noise_3d_q16_unit
// 3-D hashed value noise: floor division to lattice cell and Q16 fraction,
// smoothstep easing, eight hashed corners and seven trilinear lerps.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   cell_x, cell_z, depth
//   out      output     out_valid / out_stall noise_value
//   cfg      input      cfg_write             cfg_index, cfg_data
//
// One transaction per cycle sustained while out_stall is not holding the output;
// a sample passes the 64-bit divider (16 stages, 4 bits each), the fraction
// divider, the two hash rounds and the three lerp levels in that order.
// rst is synchronous, clears all valid bits and resets the config registers.
// A stalled output freezes the whole pipeline; in_stall follows it.
// ----------------------------------------------------------------------------
module hashed_value_noise_3d_q16_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] cell_x,
  input  logic [63:0] cell_z,
  input  logic [31:0] depth,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] noise_value,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int TailLen = 17;

  logic [63:0] world_seed;
  logic [63:0] stream_salt;
  logic [15:0] horiz_scale;
  logic [15:0] vert_scale;

  logic                  en;
  logic [15:0]           hs;
  logic [15:0]           vs;
  logic [2:0][15:0]      scale;
  logic [2:0][63:0]      axis_k;

  hvn_pkg::div_bundle_t  b0;
  hvn_pkg::div_bundle_t  bp;
  hvn_pkg::div_bundle_t  st [hvn_pkg::DivStages+1];
  hvn_pkg::div_bundle_t  fr [hvn_pkg::FracStages+1];

  logic [2:0][63:0]      g;
  logic [2:0][63:0]      g1;
  logic [63:0]           axin [3][2];
  logic [63:0]           axh  [3][2];
  logic [63:0]           cin  [8];
  logic [63:0]           ch   [8];
  logic [2:0][15:0]      te;
  logic [2:0][15:0]      t_dly [13];
  logic [TailLen-1:0]    vsh;
  logic [15:0]           x00, x10, x01, x11, v0, v1;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;
  assign out_valid = vsh[TailLen-1];

  assign hs    = (horiz_scale == 16'd0) ? 16'd1 : horiz_scale;
  assign vs    = (vert_scale == 16'd0) ? 16'd1 : vert_scale;
  assign scale = {vs, hs, hs};
  assign axis_k = {hvn_pkg::AxisYK, hvn_pkg::AxisZK, hvn_pkg::AxisXK};

  always_ff @(posedge clk) begin
    if (rst) begin
      world_seed  <= 64'd0;
      stream_salt <= 64'd0;
      horiz_scale <= 16'd18;
      vert_scale  <= 16'd6200;
    end else if (cfg_write) begin
      case (cfg_index)
        hvn_pkg::RegWorldSeed:  world_seed  <= cfg_data;
        hvn_pkg::RegStreamSalt: stream_salt <= cfg_data;
        hvn_pkg::RegHorizScale: horiz_scale <= cfg_data[15:0];
        hvn_pkg::RegVertScale:  vert_scale  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // negative coordinates divide their complement
  always_comb begin
    b0 = '0;
    b0.valid = in_valid;
    b0.neg   = {1'b0, cell_z[63], cell_x[63]};
    b0.lane[0].quo = cell_x[63] ? ~cell_x : cell_x;
    b0.lane[1].quo = cell_z[63] ? ~cell_z : cell_z;
    b0.lane[2].quo = {32'd0, depth};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st[0].valid <= 1'b0;
    end else if (en) begin
      st[0] <= b0;
    end
  end

  for (genvar k = 0; k < hvn_pkg::DivStages; k++) begin : g_div
    hvn_div_stage u_stage (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .scale (scale),
      .d_in  (st[k]),
      .d_out (st[k+1])
    );
  end

  // floor correction, then rem * 65535 as the fraction dividend
  always_comb begin
    logic [15:0] r;
    logic [31:0] p;
    bp = '0;
    bp.valid = st[hvn_pkg::DivStages].valid;
    for (int i = 0; i < 3; i++) begin
      if (st[hvn_pkg::DivStages].neg[i]) begin
        bp.grid[i] = ~st[hvn_pkg::DivStages].lane[i].quo;
        r = scale[i] - 16'd1 - st[hvn_pkg::DivStages].lane[i].rem;
      end else begin
        bp.grid[i] = st[hvn_pkg::DivStages].lane[i].quo;
        r = st[hvn_pkg::DivStages].lane[i].rem;
      end
      p = {r, 16'd0} - {16'd0, r};
      bp.lane[i].quo = {p, 32'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fr[0].valid <= 1'b0;
    end else if (en) begin
      fr[0] <= bp;
    end
  end

  for (genvar k = 0; k < hvn_pkg::FracStages; k++) begin : g_frac
    hvn_div_stage u_stage (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .scale (scale),
      .d_in  (fr[k]),
      .d_out (fr[k+1])
    );
  end

  for (genvar i = 0; i < 3; i++) begin : g_ease
    hvn_ease u_ease (
      .clk   (clk),
      .en    (en),
      .t_in  (fr[hvn_pkg::FracStages].lane[i].quo[15:0]),
      .t_out (te[i])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g  <= fr[hvn_pkg::FracStages].grid;
      for (int i = 0; i < 3; i++) begin
        g1[i] <= fr[hvn_pkg::FracStages].grid[i] + 64'd1;
        axin[i][0] <= hvn_pkg::zigzag(g[i]) + axis_k[i];
        axin[i][1] <= hvn_pkg::zigzag(g1[i]) + axis_k[i];
      end
      for (int c = 0; c < 8; c++) begin
        cin[c] <= world_seed ^ stream_salt ^ axh[0][c%2] ^ axh[2][(c/2)%2] ^ axh[1][c/4];
      end
      t_dly[0] <= te;
      for (int d = 1; d < 13; d++) begin
        t_dly[d] <= t_dly[d-1];
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_axis
    for (genvar j = 0; j < 2; j++) begin : g_end
      hvn_mix64 u_mix (
        .clk   (clk),
        .en    (en),
        .h_in  (axin[i][j]),
        .h_out (axh[i][j])
      );
    end
  end

  for (genvar c = 0; c < 8; c++) begin : g_corner
    hvn_mix64 u_mix (
      .clk   (clk),
      .en    (en),
      .h_in  (cin[c]),
      .h_out (ch[c])
    );
  end

  hvn_lerp u_x00 (.clk(clk), .en(en), .a(ch[0][15:0]), .b(ch[1][15:0]),
                  .t(t_dly[8][0]), .y(x00));
  hvn_lerp u_x10 (.clk(clk), .en(en), .a(ch[2][15:0]), .b(ch[3][15:0]),
                  .t(t_dly[8][0]), .y(x10));
  hvn_lerp u_x01 (.clk(clk), .en(en), .a(ch[4][15:0]), .b(ch[5][15:0]),
                  .t(t_dly[8][0]), .y(x01));
  hvn_lerp u_x11 (.clk(clk), .en(en), .a(ch[6][15:0]), .b(ch[7][15:0]),
                  .t(t_dly[8][0]), .y(x11));
  hvn_lerp u_v0  (.clk(clk), .en(en), .a(x00), .b(x10), .t(t_dly[10][2]), .y(v0));
  hvn_lerp u_v1  (.clk(clk), .en(en), .a(x01), .b(x11), .t(t_dly[10][2]), .y(v1));
  hvn_lerp u_out (.clk(clk), .en(en), .a(v0), .b(v1), .t(t_dly[12][1]), .y(noise_value));

  always_ff @(posedge clk) begin
    if (rst) begin
      vsh <= '0;
    end else if (en) begin
      vsh <= {vsh[TailLen-2:0], fr[hvn_pkg::FracStages].valid};
    end
  end

endmodule
